>>> hw/rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;

   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_RANK,
      ST_FINISH
   } state_type;

endpackage

>>> hw/rtl/lkvc_ram.sv
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/lkvc_scan.sv
// ----------------------------------------------------------------------------
// lkvc_scan
// Per-entry compare unit: takes one entry per cycle while en is high and tracks the key
// match, the least recent valid entry and the lowest free slot.
// ----------------------------------------------------------------------------
module lkvc_scan #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          en,
   input  logic [$clog2(DEPTH)-1:0]      chk_idx,
   input  logic                          ent_valid,
   input  logic [lkvc_pkg::DATA_W-1:0]   key,
   input  logic [lkvc_pkg::DATA_W-1:0]   rd_key,
   input  logic [lkvc_pkg::DATA_W-1:0]   rd_value,
   input  logic [$clog2(DEPTH)-1:0]      rd_rank,
   output logic                          hit,
   output logic [$clog2(DEPTH)-1:0]      hit_idx,
   output logic [$clog2(DEPTH)-1:0]      hit_rank,
   output logic [lkvc_pkg::DATA_W-1:0]   hit_value,
   output logic                          vic,
   output logic [$clog2(DEPTH)-1:0]      vic_idx,
   output logic                          free,
   output logic [$clog2(DEPTH)-1:0]      free_idx
);

   import lkvc_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]  hit_rank_ff, hit_rank_in;
   logic [DATA_W-1:0] hit_value_ff, hit_value_in;
   logic              vic_ff, vic_in;
   logic [IDX_W-1:0]  vic_idx_ff, vic_idx_in;
   logic [IDX_W-1:0]  vic_rank_ff, vic_rank_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              match;

   assign match = en && ent_valid && (rd_key == key);

   always_comb begin
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rank_in  = hit_rank_ff;
      hit_value_in = hit_value_ff;
      vic_in       = vic_ff;
      vic_idx_in   = vic_idx_ff;
      vic_rank_in  = vic_rank_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      if (start) begin
         hit_in  = 1'b0;
         vic_in  = 1'b0;
         free_in = 1'b0;
      end else begin
         if (match && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = chk_idx;
            hit_rank_in  = rd_rank;
            hit_value_in = rd_value;
         end
         if (en && ent_valid && (!vic_ff || (rd_rank > vic_rank_ff))) begin
            vic_in      = 1'b1;
            vic_idx_in  = chk_idx;
            vic_rank_in = rd_rank;
         end
         if (en && !ent_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         vic_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         vic_ff  <= vic_in;
         free_ff <= free_in;
      end
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      hit_value_ff <= hit_value_in;
      vic_idx_ff   <= vic_idx_in;
      vic_rank_ff  <= vic_rank_in;
      free_idx_ff  <= free_idx_in;
   end

   assign hit       = hit_ff;
   assign hit_idx   = hit_idx_ff;
   assign hit_rank  = hit_rank_ff;
   assign hit_value = hit_value_ff;
   assign vic       = vic_ff;
   assign vic_idx   = vic_idx_ff;
   assign free      = free_ff;
   assign free_idx  = free_idx_ff;

endmodule

>>> hw/rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
//
// req_*: one beat per operation (kind 0 = get, 1 = put, key, value).
// rsp_*: one beat per operation (found, read_value, evicted).
// csr_*: capacity write; always ready, write only while the block is idle.
// A sequencer walks the key, value and rank RAMs one entry per cycle:
// a lookup pass over every entry, a decide step, then (except on a get
// miss) a rank update pass over every entry, then a step that loads the
// response register. req_ready is high only between operations, so the block
// takes a new operation only after the last one has loaded its response;
// the entry-by-entry walk bounds the operation rate.
// Reset empties the cache (valid bits and occupancy cleared) and sets the
// capacity to 16; no clearing pass is needed. While rsp_ready is low the
// finished result waits in the response register; the next operation may
// still be accepted, but it holds in its last cycle until the beat is taken.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic signed [lkvc_pkg::DATA_W-1:0]  req_key,
   input  logic signed [lkvc_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic signed [lkvc_pkg::DATA_W-1:0]  rsp_read_value,
   output logic                                rsp_evicted,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]          csr_capacity
);

   import lkvc_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(DEPTH);
   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic              kind_ff, kind_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [IDX_W-1:0]  tgt_idx_ff, tgt_idx_in;
   logic [IDX_W-1:0]  old_rank_ff, old_rank_in;
   logic              ins_ff, ins_in;
   logic              res_found_ff, res_found_in;
   logic [DATA_W-1:0] res_value_ff, res_value_in;
   logic              res_evict_ff, res_evict_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_evict_ff, rsp_evict_in;

   logic              scan_start;
   logic              scan_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              key_we;
   logic              val_we;
   logic [IDX_W-1:0]  kv_waddr;
   logic [DATA_W-1:0] val_wdata;
   logic              rank_we;
   logic [IDX_W-1:0]  rank_waddr;
   logic [IDX_W-1:0]  rank_wdata;
   logic [DATA_W-1:0] key_rd;
   logic [DATA_W-1:0] val_rd;
   logic [IDX_W-1:0]  rank_rd;

   logic              hit;
   logic [IDX_W-1:0]  hit_idx;
   logic [IDX_W-1:0]  hit_rank;
   logic [DATA_W-1:0] hit_value;
   logic              vic;
   logic [IDX_W-1:0]  vic_idx;
   logic              free;
   logic [IDX_W-1:0]  free_idx;

   logic [CMP_W-1:0]  cap_ext;
   logic [CMP_W-1:0]  cap_eff;
   logic              full;
   logic [IDX_W-1:0]  slot;

   assign cap_ext = CMP_W'(capacity_ff);
   assign cap_eff = (cap_ext == '0) ? CMP_W'(1) :
                    ((cap_ext > DEPTH_CMP) ? DEPTH_CMP : cap_ext);
   assign full    = CMP_W'(occ_ff) >= cap_eff;
   assign slot    = (full && !(free && (free_idx < vic_idx))) ? vic_idx : free_idx;
   assign scan_en = chk_vld_ff && (state_ff == ST_SCAN);

   lkvc_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (kv_waddr),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   lkvc_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (kv_waddr),
      .wr_data (val_wdata),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   lkvc_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rank_waddr),
      .wr_data (rank_wdata),
      .rd_addr (rd_addr),
      .rd_data (rank_rd)
   );

   lkvc_scan #(.DEPTH(DEPTH)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .en        (scan_en),
      .chk_idx   (chk_idx_ff),
      .ent_valid (valid_ff[chk_idx_ff]),
      .key       (key_ff),
      .rd_key    (key_rd),
      .rd_value  (val_rd),
      .rd_rank   (rank_rd),
      .hit       (hit),
      .hit_idx   (hit_idx),
      .hit_rank  (hit_rank),
      .hit_value (hit_value),
      .vic       (vic),
      .vic_idx   (vic_idx),
      .free      (free),
      .free_idx  (free_idx)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = cnt_ff[IDX_W-1:0];
      kind_in      = kind_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      capacity_in  = csr_valid ? csr_capacity : capacity_ff;
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      tgt_idx_in   = tgt_idx_ff;
      old_rank_in  = old_rank_ff;
      ins_in       = ins_ff;
      res_found_in = res_found_ff;
      res_value_in = res_value_ff;
      res_evict_in = res_evict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      rsp_evict_in = rsp_evict_ff;
      scan_start   = 1'b0;
      rd_addr      = cnt_ff[IDX_W-1:0];
      key_we       = 1'b0;
      val_we       = 1'b0;
      kv_waddr     = slot;
      val_wdata    = value_ff;
      rank_we      = 1'b0;
      rank_waddr   = chk_idx_ff;
      rank_wdata   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in    = req_kind;
               key_in     = req_key;
               value_in   = req_value;
               cnt_in     = '0;
               scan_start = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != CNT_END) begin
               chk_vld_in = 1'b1;
               cnt_in     = CNT_W'(cnt_ff + 1'b1);
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cnt_in       = '0;
            res_found_in = hit;
            res_value_in = '0;
            res_evict_in = 1'b0;
            state_in     = ST_RANK;
            if (hit) begin
               tgt_idx_in  = hit_idx;
               old_rank_in = hit_rank;
               ins_in      = 1'b0;
               if (kind_ff == KIND_GET) begin
                  res_value_in = hit_value;
               end else begin
                  val_we   = 1'b1;
                  kv_waddr = hit_idx;
               end
            end else if (kind_ff == KIND_GET) begin
               res_value_in = MISS_VALUE;
               state_in     = ST_FINISH;
            end else begin
               key_we     = 1'b1;
               val_we     = 1'b1;
               kv_waddr   = slot;
               tgt_idx_in = slot;
               ins_in     = 1'b1;
               if (full && vic) begin
                  res_evict_in      = 1'b1;
                  valid_in[vic_idx] = 1'b0;
               end else begin
                  occ_in = CNT_W'(occ_ff + 1'b1);
               end
               valid_in[slot] = 1'b1;
            end
         end
         ST_RANK: begin
            if (cnt_ff != CNT_END) begin
               chk_vld_in = 1'b1;
               cnt_in     = CNT_W'(cnt_ff + 1'b1);
            end else begin
               state_in = ST_FINISH;
            end
            if (chk_vld_ff) begin
               if (chk_idx_ff == tgt_idx_ff) begin
                  rank_we    = 1'b1;
                  rank_wdata = '0;
               end else if (valid_ff[chk_idx_ff] && (ins_ff || (rank_rd < old_rank_ff))) begin
                  rank_we    = 1'b1;
                  rank_wdata = IDX_W'(rank_rd + 1'b1);
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_value_in = res_value_ff;
               rsp_evict_in = res_evict_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         capacity_ff  <= CAP_RESET;
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_vld_ff   <= chk_vld_in;
         capacity_ff  <= capacity_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_idx_ff   <= chk_idx_in;
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      tgt_idx_ff   <= tgt_idx_in;
      old_rank_ff  <= old_rank_in;
      ins_ff       <= ins_in;
      res_found_ff <= res_found_in;
      res_value_ff <= res_value_in;
      res_evict_ff <= res_evict_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_evict_ff <= rsp_evict_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evict_ff;

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lru_key_value_cache_unit. A directed table walks
// the empty store, key and value extremes, capacity zero, capacity above the
// depth and a capacity cut below the occupancy. Random get/put traffic over
// small per-segment key pools follows, so hits, misses and evictions are
// frequent. Each beat is checked against an in-bench LRU model or a typed row's result.
// ----------------------------------------------------------------------------
module tb;
   import lkvc_pkg::*;

   localparam int DEPTH = 16;

   typedef struct packed {
      logic              found;
      logic [DATA_W-1:0] read_value;
      logic              evicted;
   } cache_result_type;

   typedef enum logic {ROW_REQ, ROW_CFG} row_what_type;

   typedef struct packed {
      row_what_type      what;
      logic              kind;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      logic [CAP_W-1:0]  cap;
      logic              typed;
      cache_result_type  want;
   } dir_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_kind = KIND_GET;
   logic signed [DATA_W-1:0] req_key = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_found;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic                    rsp_evicted;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CAP_W-1:0]        csr_capacity = '0;

   logic                    cur_typed = 1'b0;
   cache_result_type        cur_want = '0;

   int                      req_idle_pct = 15;
   int                      rsp_idle_pct = 87;
   int                      bad_beats = 0;

   cache_result_type        pending_results[$];
   dir_row_type             dir_rows[$];

   // LRU model state
   logic                    slot_valid [DEPTH];
   logic [DATA_W-1:0]       slot_key   [DEPTH];
   logic [DATA_W-1:0]       slot_value [DEPTH];
   int                      slot_rank  [DEPTH];
   int                      fill;
   logic [CAP_W-1:0]        model_cap;

   lru_key_value_cache_unit #(.DEPTH(DEPTH)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value),
      .rsp_evicted    (rsp_evicted),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_capacity   (csr_capacity)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #6000000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic void clear_model();
      for (int i = 0; i < DEPTH; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_rank[i]  = 0;
      end
      fill      = 0;
      model_cap = CAP_RESET;
   endfunction

   function automatic void promote_slot(int idx);
      int old;
      old = slot_rank[idx];
      for (int j = 0; j < DEPTH; j++) begin
         if (slot_valid[j] && j != idx && slot_rank[j] < old) slot_rank[j]++;
      end
      slot_rank[idx] = 0;
   endfunction

   function automatic cache_result_type lru_predict(logic kind, logic [DATA_W-1:0] k,
                                                    logic [DATA_W-1:0] v);
      cache_result_type r;
      int               hit;
      int               victim;
      int               slot;
      int               cap_eff;
      r   = '0;
      hit = -1;
      for (int i = 0; i < DEPTH; i++) begin
         if (hit < 0 && slot_valid[i] && slot_key[i] == k) hit = i;
      end
      r.found = (hit >= 0);
      if (kind == KIND_GET) begin
         if (hit >= 0) begin
            r.read_value = slot_value[hit];
            promote_slot(hit);
         end else begin
            r.read_value = MISS_VALUE;
         end
      end else if (hit >= 0) begin
         slot_value[hit] = v;
         promote_slot(hit);
      end else begin
         cap_eff = (model_cap == 0) ? 1 : ((model_cap > DEPTH) ? DEPTH : int'(model_cap));
         if (fill >= cap_eff) begin
            victim = -1;
            for (int i = 0; i < DEPTH; i++) begin
               if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                  victim = i;
            end
            if (victim >= 0) begin
               slot_valid[victim] = 1'b0;
               slot_rank[victim]  = 0;
               if (fill > 0) fill--;
               r.evicted = 1'b1;
            end
         end
         slot = -1;
         for (int i = 0; i < DEPTH; i++) begin
            if (slot < 0 && !slot_valid[i]) slot = i;
         end
         if (slot >= 0) begin
            for (int i = 0; i < DEPTH; i++) begin
               if (slot_valid[i]) slot_rank[i]++;
            end
            slot_valid[slot] = 1'b1;
            slot_key[slot]   = k;
            slot_value[slot] = v;
            slot_rank[slot]  = 0;
            fill++;
         end
      end
      return r;
   endfunction

   // model update and response check, all on sampled values
   always @(posedge clock) begin : monitor
      cache_result_type want;
      cache_result_type got;
      if (reset) begin
         clear_model();
      end else begin
         if (csr_valid && csr_ready) model_cap = csr_capacity;
         if (req_valid && req_ready) begin
            want = lru_predict(req_kind, req_key, req_value);
            if (cur_typed) want = cur_want;
            pending_results.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got.found      = rsp_found;
            got.read_value = rsp_read_value;
            got.evicted    = rsp_evicted;
            if (pending_results.size() == 0) begin
               bad_beats++;
               if (bad_beats <= 10)
                  $display("unexpected rsp beat: found %0d read_value %h evicted %0d",
                           got.found, got.read_value, got.evicted);
            end else begin
               want = pending_results.pop_front();
               if (got.found !== want.found || got.read_value !== want.read_value ||
                   got.evicted !== want.evicted) begin
                  bad_beats++;
                  if (bad_beats <= 10)
                     $display("rsp mismatch: found %0d/%0d read_value %h/%h evicted %0d/%0d",
                              want.found, got.found, want.read_value, got.read_value,
                              want.evicted, got.evicted);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic send_req(logic kind, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v,
                           logic typed, cache_result_type want);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_key   <= k;
      req_value <= v;
      cur_typed <= typed;
      cur_want  <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] c);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid    <= 1'b1;
      csr_capacity <= c;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_row(row_what_type what, logic kind, logic [DATA_W-1:0] k,
                                   logic [DATA_W-1:0] v, logic [CAP_W-1:0] cap,
                                   logic typed, logic f, logic [DATA_W-1:0] rd, logic ev);
      dir_row_type row;
      row.what            = what;
      row.kind            = kind;
      row.key             = k;
      row.value           = v;
      row.cap             = cap;
      row.typed           = typed;
      row.want.found      = f;
      row.want.read_value = rd;
      row.want.evicted    = ev;
      dir_rows.push_back(row);
   endfunction

   function automatic logic [DATA_W-1:0] extreme_word();
      case ($urandom_range(3))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         default: return 32'h0000_0000;
      endcase
   endfunction

   initial begin : stimulus
      logic [DATA_W-1:0] key_pool[$];
      logic [DATA_W-1:0] k;
      logic [DATA_W-1:0] v;
      logic              kind;
      int                caps[12] = '{4, 16, 1, 31, 21, 10, 0, 3, 2, 8, 17, 5};
      int                cap_eff;

      // empty store, key/value extremes
      add_row(ROW_REQ, KIND_GET, 32'h0000_0000, 32'h0, '0, 1, 0, MISS_VALUE, 0);
      add_row(ROW_REQ, KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF, '0, 1, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000, '0, 1, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_GET, 32'h8000_0000, 32'h0, '0, 1, 1, 32'h7FFF_FFFF, 0);
      add_row(ROW_REQ, KIND_GET, 32'h7FFF_FFFF, 32'h0, '0, 1, 1, 32'h8000_0000, 0);
      add_row(ROW_REQ, KIND_PUT, 32'h8000_0000, 32'h0, '0, 1, 1, 32'h0, 0);
      add_row(ROW_REQ, KIND_GET, 32'hFFFF_FFFF, 32'h0, '0, 1, 0, MISS_VALUE, 0);
      add_row(ROW_REQ, KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_GET, 32'h8000_0000, 32'h0, '0, 1, 1, 32'h0, 0);
      // zero capacity acts as one, below the current occupancy
      add_row(ROW_CFG, KIND_GET, 32'h0, 32'h0, 5'd0, 0, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_PUT, 32'd5, 32'd55, '0, 0, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_PUT, 32'd6, 32'd66, '0, 0, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_GET, 32'd5, 32'h0, '0, 0, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_GET, 32'd6, 32'h0, '0, 0, 0, 32'h0, 0);
      // capacity above depth saturates
      add_row(ROW_CFG, KIND_GET, 32'h0, 32'h0, 5'd31, 0, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_PUT, 32'd7, 32'd77, '0, 0, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_PUT, 32'd8, 32'd88, '0, 0, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_GET, 32'd6, 32'h0, '0, 0, 0, 32'h0, 0);
      add_row(ROW_CFG, KIND_GET, 32'h0, 32'h0, 5'd2, 0, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_PUT, 32'd9, 32'd99, '0, 0, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_GET, 32'd7, 32'h0, '0, 0, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_PUT, 32'd8, 32'd1, '0, 0, 0, 32'h0, 0);
      add_row(ROW_REQ, KIND_GET, 32'd9, 32'h0, '0, 0, 0, 32'h0, 0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].what == ROW_CFG) write_capacity(dir_rows[i].cap);
         else send_req(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].value,
                       dir_rows[i].typed, dir_rows[i].want);
      end

      for (int seg = 0; seg < 12; seg++) begin
         case (seg / 4)
            0: begin
               req_idle_pct = 15;
               rsp_idle_pct = 87;
            end
            1: begin
               req_idle_pct = 87;
               rsp_idle_pct = 15;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         write_capacity(CAP_W'(caps[seg]));
         cap_eff = (caps[seg] == 0) ? 1 : ((caps[seg] > DEPTH) ? DEPTH : caps[seg]);
         key_pool.delete();
         repeat (cap_eff + $urandom_range(1, 6)) begin
            key_pool.push_back(($urandom_range(7) == 0) ? extreme_word() : $urandom);
         end
         repeat (144) begin
            k    = ($urandom_range(99) < 90) ? key_pool[$urandom_range(key_pool.size() - 1)]
                                             : $urandom;
            v    = ($urandom_range(15) == 0) ? extreme_word() : $urandom;
            kind = ($urandom_range(99) < 55) ? KIND_PUT : KIND_GET;
            send_req(kind, k, v, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (2 * DEPTH + 8) @(negedge clock);
      if (bad_beats == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_ram.sv
hw/rtl/lkvc_scan.sv
hw/rtl/lru_key_value_cache_unit.sv
sim/tb.sv
